FILE: rtl/i8mm_pkg.sv
`timescale 1ns / 1ps

package i8mm_pkg;

    localparam int STORE_DEPTH  = 1024;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int MAX_TILE_DIM = 32;
    localparam int DIM_W        = 6;
    localparam int CFG_W        = 6;
    localparam int CFG_IDX_W    = 1;

    localparam logic [2:0] FUNC_WR_A    = 3'd0;
    localparam logic [2:0] FUNC_WR_B    = 3'd1;
    localparam logic [2:0] FUNC_CMP_OVR = 3'd2;
    localparam logic [2:0] FUNC_CMP_ACC = 3'd3;
    localparam logic [2:0] FUNC_RD_C    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_K_STRIDE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_ROW_STRIDE = 1'd1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [2:0]        func;
        logic [9:0]        addr;
        logic signed [7:0] value;
        logic [5:0]        eff_m;
        logic [5:0]        eff_n;
        logic [5:0]        eff_k;
    } in_beat_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] read_data;
    } out_beat_t;

    typedef struct packed {
        logic              a_wr;
        logic              b_wr;
        logic [ADDR_W-1:0] wr_addr;
        logic signed [7:0] wr_value;
        logic              ab_rd;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              acc_clear;
        logic              c_rd;
        logic              c_wr;
        logic [ADDR_W-1:0] c_addr;
        logic              accumulate;
        logic              out_load;
        logic              out_kind;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/i8mm_ctrl.sv
`timescale 1ns / 1ps

module i8mm_ctrl
    import i8mm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output cmd_t                 cmd,
    input  status_t              sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_C,
        ST_READ_OUT,
        ST_SETUP,
        ST_DOT,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_C_FETCH,
        ST_C_WRITE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [DIM_W-1:0]    k_stride_reg;
    logic [DIM_W-1:0]    c_stride_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                accum_reg;
    logic [DIM_W-1:0]    m_reg, n_reg, k_reg;
    logic [DIM_W-1:0]    i_reg, j_reg, kk_reg;
    logic [ADDR_W-1:0]   a_row_reg, b_col_reg, c_row_reg;
    logic [ADDR_W-1:0]   a_ptr_reg, b_ptr_reg;

    logic                accept;
    logic [DIM_W-1:0]    sat_m, sat_n, sat_k;
    logic [ADDR_W-1:0]   k_step, c_step;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_TILE_DIM);
        return (v > lim) ? lim : v;
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign sat_m   = sat_dim(s_data.eff_m);
    assign sat_n   = sat_dim(s_data.eff_n);
    assign sat_k   = sat_dim(s_data.eff_k);
    assign k_step  = ADDR_W'(k_stride_reg);
    assign c_step  = ADDR_W'(c_stride_reg);

    always_comb begin
        cmd            = '0;
        cmd.a_wr       = accept && (s_data.func == FUNC_WR_A);
        cmd.b_wr       = accept && (s_data.func == FUNC_WR_B);
        cmd.wr_addr    = s_data.addr[ADDR_W-1:0];
        cmd.wr_value   = s_data.value;
        cmd.ab_rd      = (state_reg == ST_DOT);
        cmd.a_addr     = a_ptr_reg;
        cmd.b_addr     = b_ptr_reg;
        cmd.acc_clear  = (state_reg == ST_SETUP);
        cmd.c_rd       = (state_reg == ST_READ_C) || (state_reg == ST_C_FETCH);
        cmd.c_wr       = (state_reg == ST_C_WRITE);
        cmd.c_addr     = (state_reg == ST_READ_C) ? addr_reg
                                                  : c_row_reg + ADDR_W'(j_reg);
        cmd.accumulate = accum_reg;
        cmd.out_load   = ((state_reg == ST_READ_OUT) || (state_reg == ST_DONE))
                         && !sts.out_busy;
        cmd.out_kind   = (state_reg == ST_DONE) ? KIND_DONE : KIND_READ;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_stride_reg <= DIM_W'(MAX_TILE_DIM);
            c_stride_reg <= DIM_W'(MAX_TILE_DIM);
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_K_STRIDE:     k_stride_reg <= sat_dim(cfg_wdata);
                    REG_C_ROW_STRIDE: c_stride_reg <= sat_dim(cfg_wdata);
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_data.func)
                            FUNC_CMP_OVR, FUNC_CMP_ACC: begin
                                m_reg     <= sat_m;
                                n_reg     <= sat_n;
                                k_reg     <= sat_k;
                                accum_reg <= (s_data.func == FUNC_CMP_ACC);
                                i_reg     <= '0;
                                j_reg     <= '0;
                                a_row_reg <= '0;
                                b_col_reg <= '0;
                                c_row_reg <= '0;
                                if ((sat_m == '0) || (sat_n == '0)) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_SETUP;
                                end
                            end
                            FUNC_RD_C: begin
                                addr_reg  <= s_data.addr[ADDR_W-1:0];
                                state_reg <= ST_READ_C;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ_C: begin
                    state_reg <= ST_READ_OUT;
                end
                ST_READ_OUT: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SETUP: begin
                    a_ptr_reg <= a_row_reg;
                    b_ptr_reg <= b_col_reg;
                    kk_reg    <= '0;
                    state_reg <= (k_reg == '0) ? ST_DRAIN1 : ST_DOT;
                end
                ST_DOT: begin
                    a_ptr_reg <= a_ptr_reg + 1'b1;
                    b_ptr_reg <= b_ptr_reg + 1'b1;
                    kk_reg    <= kk_reg + 1'b1;
                    if (kk_reg == k_reg - 1'b1) begin
                        state_reg <= ST_DRAIN1;
                    end
                end
                ST_DRAIN1: begin
                    state_reg <= ST_DRAIN2;
                end
                ST_DRAIN2: begin
                    state_reg <= ST_C_FETCH;
                end
                ST_C_FETCH: begin
                    state_reg <= ST_C_WRITE;
                end
                ST_C_WRITE: begin
                    if (j_reg == n_reg - 1'b1) begin
                        j_reg     <= '0;
                        b_col_reg <= '0;
                        if (i_reg == m_reg - 1'b1) begin
                            state_reg <= ST_DONE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            a_row_reg <= a_row_reg + k_step;
                            c_row_reg <= c_row_reg + c_step;
                            state_reg <= ST_SETUP;
                        end
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        b_col_reg <= b_col_reg + k_step;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_DONE: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/i8mm_datapath.sv
`timescale 1ns / 1ps

module i8mm_datapath
    import i8mm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    output status_t   sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic signed [7:0]  a_mem [STORE_DEPTH];
    logic signed [7:0]  b_mem [STORE_DEPTH];
    logic [15:0]        c_mem [STORE_DEPTH];

    logic signed [7:0]  a_q_reg, b_q_reg;
    logic [15:0]        c_q_reg;
    logic               rd_v_reg, prod_v_reg;
    logic signed [15:0] prod_reg;
    logic [15:0]        acc_reg;
    logic [15:0]        c_wdata;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.a_wr) begin
            a_mem[cmd.wr_addr] <= cmd.wr_value;
        end
        if (cmd.ab_rd) begin
            a_q_reg <= a_mem[cmd.a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.b_wr) begin
            b_mem[cmd.wr_addr] <= cmd.wr_value;
        end
        if (cmd.ab_rd) begin
            b_q_reg <= b_mem[cmd.b_addr];
        end
    end

    assign c_wdata = cmd.accumulate ? (c_q_reg + acc_reg) : acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.c_wr) begin
            c_mem[cmd.c_addr] <= c_wdata;
        end
        if (cmd.c_rd) begin
            c_q_reg <= c_mem[cmd.c_addr];
        end
    end

    // read -> multiply -> accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= cmd.ab_rd;
            prod_v_reg <= rd_v_reg;
        end
        prod_reg <= a_q_reg * b_q_reg;
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.kind      <= cmd.out_kind;
            m_data_reg.read_data <= (cmd.out_kind == KIND_READ) ? c_q_reg : 16'sd0;
        end
    end

    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

FILE: rtl/int8_tile_matmul_accumulate.sv
`timescale 1ns / 1ps

// Signed 8-bit tile matrix multiply with 16-bit wrapping accumulate into a C store.
// A write-A or write-B beat returns nothing; a read-C beat returns its element. A
// compute beat walks the outputs one at a time through a single multiply-accumulate
// unit fed by one read port on each of the A and B memories, with m, n and k saturated
// to the tile size, and returns one completion beat. The next beat is taken once
// the previous one has left the sequencer; one finished result waits in the output
// register.
// The stores have no reset; reading an entry that was never written gives undefined data.
module int8_tile_matmul_accumulate
    import i8mm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data
);

    cmd_t    cmd;
    status_t sts;

    i8mm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    i8mm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
